/* hw/rtl/lmb_pkg.sv */
package lmb_pkg;

  // default build parameters
  localparam int MAX_WINDOW_DEF  = 65536;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int LVL_W = 16;
  localparam int OUT_W = 15;
  localparam logic signed [LVL_W-1:0] FLOOR_DB = -16'sd15360;

  // 10*log10(2)*256 in Q16
  localparam logic [25:0] DB_K = 26'd50504453;

  localparam int QUEUE_DEPTH = 2;

  // item kinds on the input channel
  localparam logic [1:0] MODE_FRAME = 2'd0;
  localparam logic [1:0] MODE_EMPTY = 2'd1;

  // meter modes
  localparam logic [1:0] MM_PPM = 2'd0;
  localparam logic [1:0] MM_VU  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_METER_MODE = 2'd0;
  localparam logic [1:0] CFG_STEREO     = 2'd1;
  localparam logic [1:0] CFG_GAIN       = 2'd2;
  localparam logic [1:0] CFG_HOLD_TICKS = 2'd3;

  typedef enum logic [1:0] {
    CMD_CLOSE,
    CMD_EMPTY,
    CMD_STOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic      act_l;
    logic      act_r;
    logic      played;
  } cmd_ctl_t;

  typedef struct packed {
    logic [1:0]  meter_mode;
    logic        stereo;
    logic [15:0] gain;
    logic [7:0]  hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [16:0] atk;
    logic signed [16:0] dec;
    logic signed [16:0] pkd;
    logic signed [16:0] hdd;
  } rates_t;

  function automatic rates_t get_rates(logic [1:0] mm);
    rates_t r;
    if (mm == MM_PPM) begin
      r = '{atk: 17'sd0, dec: 17'sd128, pkd: 17'sd77, hdd: 17'sd77};
    end else if (mm == MM_VU) begin
      r = '{atk: 17'sd563, dec: 17'sd563, pkd: 17'sd77, hdd: 17'sd77};
    end else begin
      r = '{atk: 17'sd0, dec: 17'sd768, pkd: 17'sd384, hdd: 17'sd384};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/lmb_fifo.sv */
module lmb_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o
);
  import lmb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [W-1:0]  mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign push_ready_o = cnt_q < (PW+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i && push_ready_o) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && push_ready_o) wr_q <= wr_q + 1'b1;
      if (pop_i && pop_valid_o)   rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i && push_ready_o) - (PW+1)'(pop_i && pop_valid_o);
    end
  end

endmodule

/* hw/rtl/lmb_front.sv */
module lmb_front #(
  parameter int SB = 24,
  parameter int MW = 65536,
  parameter int AW = SB + 1,
  parameter int CW = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic signed [SB-1:0] sample_l_i,
  input  logic signed [SB-1:0] sample_r_i,
  input  logic                 last_i,
  input  logic                 active_l_i,
  input  logic                 active_r_i,
  input  logic [15:0]          gain_i,
  output logic                 push_o,
  input  logic                 push_ready_i,
  output lmb_pkg::cmd_ctl_t    ctl_o,
  output logic [63:0]          sum_l_o,
  output logic [63:0]          sum_r_o,
  output logic [AW-1:0]        pk_l_o,
  output logic [AW-1:0]        pk_r_o,
  output logic [CW-1:0]        cnt_o
);
  import lmb_pkg::*;

  typedef struct packed {
    logic [1:0] mode;
    logic       last;
    logic       act_l;
    logic       act_r;
  } tag_t;

  // stage 1: captured request
  logic                 s1_v_q;
  tag_t                 s1_tag_q;
  logic signed [SB-1:0] s1_l_q, s1_r_q;
  // stage 2: gained magnitudes
  logic                 s2_v_q;
  tag_t                 s2_tag_q;
  logic [AW-1:0]        s2_a_q [2];
  // stage 3: squares
  logic                 s3_v_q;
  tag_t                 s3_tag_q;
  logic [AW-1:0]        s3_a_q [2];
  logic [63:0]          s3_sq_q [2];
  // window accumulators
  logic [63:0]          sum_q [2];
  logic [AW-1:0]        pk_q [2];
  logic [CW-1:0]        cnt_q;
  logic                 wp_q;

  logic                 adv;
  logic                 s3_push;
  logic                 s3_frame;
  logic                 close;
  logic [CW-1:0]        cnt_nx;
  logic [63:0]          sum_nx [2];
  logic [AW-1:0]        pk_nx [2];
  logic [SB-1:0]        mag [2];
  logic [AW-1:0]        a_nx [2];
  logic [63:0]          sq_nx [2];
  logic [64:0]          add [2];
  logic [63:0]          a64 [2];

  // magnitude times gain, square
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      logic signed [SB-1:0] s;
      s = (c == 0) ? s1_l_q : s1_r_q;
      mag[c]  = s[SB-1] ? SB'(-s) : SB'(s);
      a_nx[c] = AW'(((SB+16)'(mag[c]) * (SB+16)'(gain_i)) >> 14);
      a64[c]  = 64'(s2_a_q[c]);
      sq_nx[c] = (|a64[c][63:32]) ? '1 : 64'(s2_a_q[c] * s2_a_q[c]);
    end
  end

  // accumulate at stage 3
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      add[c]    = {1'b0, sum_q[c]} + {1'b0, s3_sq_q[c]};
      sum_nx[c] = add[c][64] ? '1 : add[c][63:0];
      pk_nx[c]  = (s3_a_q[c] > pk_q[c]) ? s3_a_q[c] : pk_q[c];
    end
    cnt_nx   = (cnt_q < CW'(MW)) ? cnt_q + 1'b1 : cnt_q;
    s3_frame = s3_tag_q.mode == MODE_FRAME;
    close    = s3_tag_q.last || (cnt_nx == CW'(MW));
    s3_push  = !s3_frame || close;
  end

  assign adv        = !(s3_v_q && s3_push && !push_ready_i);
  assign in_ready_o = adv;
  assign push_o     = s3_v_q && s3_push;

  always_comb begin
    ctl_o.act_l  = s3_tag_q.act_l;
    ctl_o.act_r  = s3_tag_q.act_r;
    ctl_o.played = wp_q;
    if (s3_frame)                        ctl_o.kind = CMD_CLOSE;
    else if (s3_tag_q.mode == MODE_EMPTY) ctl_o.kind = CMD_EMPTY;
    else                                 ctl_o.kind = CMD_STOP;
  end

  assign sum_l_o = sum_nx[0];
  assign sum_r_o = sum_nx[1];
  assign pk_l_o  = pk_nx[0];
  assign pk_r_o  = pk_nx[1];
  assign cnt_o   = cnt_nx;

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tag_q <= '{mode: mode_i, last: last_i, act_l: active_l_i, act_r: active_r_i};
      s1_l_q   <= sample_l_i;
      s1_r_q   <= sample_r_i;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
      for (int c = 0; c < 2; c++) begin
        s2_a_q[c]  <= a_nx[c];
        s3_a_q[c]  <= s2_a_q[c];
        s3_sq_q[c] <= sq_nx[c];
      end
    end
  end

  // valids and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      wp_q   <= 1'b0;
      cnt_q  <= '0;
      for (int c = 0; c < 2; c++) begin
        sum_q[c] <= '0;
        pk_q[c]  <= '0;
      end
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (s3_v_q) begin
        wp_q <= s3_frame || (s3_tag_q.mode == MODE_EMPTY);
        if (s3_frame && !close) begin
          cnt_q <= cnt_nx;
          for (int c = 0; c < 2; c++) begin
            sum_q[c] <= sum_nx[c];
            pk_q[c]  <= pk_nx[c];
          end
        end else begin
          cnt_q <= '0;
          for (int c = 0; c < 2; c++) begin
            sum_q[c] <= '0;
            pk_q[c]  <= '0;
          end
        end
      end
    end
  end

endmodule

/* hw/rtl/lmb_back.sv */
module lmb_back #(
  parameter int SB = 24,
  parameter int AW = SB + 1,
  parameter int CW = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lmb_pkg::cfg_t        cfg_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  input  lmb_pkg::cmd_ctl_t    ctl_i,
  input  logic [63:0]          sum_l_i,
  input  logic [63:0]          sum_r_i,
  input  logic [AW-1:0]        pk_l_i,
  input  logic [AW-1:0]        pk_r_i,
  input  logic [CW-1:0]        cnt_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [lmb_pkg::OUT_W-1:0] bar_l_o,
  output logic [lmb_pkg::OUT_W-1:0] bar_r_o,
  output logic [lmb_pkg::OUT_W-1:0] peak_l_o,
  output logic [lmb_pkg::OUT_W-1:0] peak_r_o,
  output logic [lmb_pkg::OUT_W-1:0] hold_l_o,
  output logic [lmb_pkg::OUT_W-1:0] hold_r_o
);
  import lmb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_NORM, ST_LOG, ST_FIN, ST_DB, ST_APPLY, ST_OUT
  } state_e;

  localparam logic signed [23:0] BIAS = 24'((2 * (SB - 1)) << 16);
  localparam logic [22:0] T_MAX = 23'(21 << 16);

  typedef logic signed [LVL_W-1:0] lvl_t;

  state_e        state_q;
  cmd_ctl_t      ctl_q;
  logic [63:0]   sum_q [2];
  logic [AW-1:0] pk_q [2];
  logic [CW-1:0] n_q;
  logic          ch_q;
  logic          mean_q;
  logic [63:0]   w_q;
  logic [CW-1:0] rem_q;
  logic [5:0]    it_q;
  logic [5:0]    e_q;
  logic [15:0]   f_q;
  logic [31:0]   m_q;
  logic [47:0]   prod_q;
  lvl_t          tp_q [2], tb_q [2];
  lvl_t          bar_q [2], peak_q [2], hold_q [2];
  logic [7:0]    hcnt_q [2];
  logic          out_v_q;

  rates_t        r;
  logic [63:0]   p;
  logic [CW:0]   rem_sh;
  logic signed [23:0] lraw, lval;
  logic [22:0]   t;
  logic [15:0]   mag;
  logic          lvl_done;
  lvl_t          lvl;
  lvl_t          tb_t [2], tp_t [2];
  lvl_t          bar_n [2], peak_n [2], hold_n [2];
  logic [7:0]    hcnt_n [2];
  logic          above;

  assign r = get_rates(cfg_i.meter_mode);

  function automatic lvl_t fall(lvl_t cur, logic signed [16:0] step);
    logic signed [16:0] v;
    v = 17'(cur) - step;
    return (v < 17'(FLOOR_DB)) ? FLOOR_DB : v[LVL_W-1:0];
  endfunction

  // divider step, log step, level conversion
  always_comb begin
    rem_sh = {rem_q, w_q[63]};
    p      = m_q * m_q;
    lraw   = 24'({e_q, f_q});
    lval   = (mean_q ? lraw : (lraw <<< 1)) - BIAS;
    t      = 23'(-lval);
    mag    = prod_q[47:32];
    lvl_done = 1'b0;
    lvl      = FLOOR_DB;
    if (state_q == ST_NORM && w_q == '0) begin
      lvl_done = 1'b1;
    end else if (state_q == ST_FIN) begin
      if (!lval[23]) begin
        lvl_done = 1'b1;
        lvl      = '0;
      end else if (t > T_MAX) begin
        lvl_done = 1'b1;
      end
    end else if (state_q == ST_DB) begin
      lvl_done = 1'b1;
      lvl      = (mag > 16'd15360) ? FLOOR_DB : -lvl_t'(mag);
    end
  end

  // ballistics for both channels
  always_comb begin
    tb_t[0] = tb_q[0];
    tp_t[0] = tp_q[0];
    tb_t[1] = cfg_i.stereo ? tb_q[1] : tb_q[0];
    tp_t[1] = cfg_i.stereo ? tp_q[1] : tp_q[0];
    if (!ctl_q.act_l) begin
      tb_t[0] = FLOOR_DB;
      tp_t[0] = FLOOR_DB;
    end
    if (cfg_i.stereo && !ctl_q.act_r) begin
      tb_t[1] = FLOOR_DB;
      tp_t[1] = FLOOR_DB;
    end
    above = (bar_q[0] > FLOOR_DB) || (bar_q[1] > FLOOR_DB);
    for (int c = 0; c < 2; c++) begin
      logic signed [16:0] up, dn;
      bar_n[c]  = bar_q[c];
      peak_n[c] = peak_q[c];
      hold_n[c] = hold_q[c];
      hcnt_n[c] = hcnt_q[c];
      up = 17'(bar_q[c]) + r.atk;
      dn = 17'(bar_q[c]) - r.dec;
      case (ctl_q.kind)
        CMD_CLOSE: begin
          if (tb_t[c] > bar_q[c]) begin
            bar_n[c] = (r.atk == '0 || 17'(tb_t[c]) < up) ? tb_t[c] : up[LVL_W-1:0];
          end else begin
            bar_n[c] = (dn > 17'(tb_t[c])) ? dn[LVL_W-1:0] : tb_t[c];
          end
          dn = 17'(peak_q[c]) - r.pkd;
          if (tp_t[c] > peak_q[c]) peak_n[c] = tp_t[c];
          else peak_n[c] = (dn > 17'(tp_t[c])) ? dn[LVL_W-1:0] : tp_t[c];
          if (tp_t[c] >= hold_q[c]) begin
            hold_n[c] = tp_t[c];
            hcnt_n[c] = '0;
          end else begin
            if (hcnt_q[c] != 8'hFF) hcnt_n[c] = hcnt_q[c] + 1'b1;
            if (hcnt_q[c] >= cfg_i.hold_ticks) begin
              dn = 17'(hold_q[c]) - r.hdd;
              hold_n[c] = (dn > 17'(tp_t[c])) ? dn[LVL_W-1:0] : tp_t[c];
            end
          end
        end
        CMD_EMPTY: begin
          bar_n[c]  = fall(bar_q[c], r.dec);
          peak_n[c] = fall(peak_q[c], r.pkd);
        end
        CMD_STOP: begin
          if (ctl_q.played || above) begin
            bar_n[c]  = fall(bar_q[c], r.dec);
            peak_n[c] = fall(peak_q[c], r.pkd);
            hold_n[c] = fall(hold_q[c], r.hdd);
          end
        end
        default: ;
      endcase
    end
  end

  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign out_valid_o = out_v_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
      ch_q    <= 1'b0;
      mean_q  <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        bar_q[c]  <= FLOOR_DB;
        peak_q[c] <= FLOOR_DB;
        hold_q[c] <= FLOOR_DB;
        hcnt_q[c] <= '0;
      end
    end else begin
      if (out_v_q && out_ready_i && state_q != ST_OUT) out_v_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            ctl_q    <= ctl_i;
            sum_q[0] <= sum_l_i;
            sum_q[1] <= sum_r_i;
            pk_q[0]  <= pk_l_i;
            pk_q[1]  <= pk_r_i;
            n_q      <= cnt_i;
            ch_q     <= 1'b0;
            mean_q   <= 1'b0;
            w_q      <= 64'(pk_l_i);
            e_q      <= 6'd63;
            state_q  <= (ctl_i.kind == CMD_CLOSE) ? ST_NORM : ST_APPLY;
          end
        end
        ST_DIV: begin
          if (rem_sh >= {1'b0, n_q}) begin
            rem_q <= CW'(rem_sh - {1'b0, n_q});
            w_q   <= {w_q[62:0], 1'b1};
          end else begin
            rem_q <= rem_sh[CW-1:0];
            w_q   <= {w_q[62:0], 1'b0};
          end
          it_q <= it_q + 1'b1;
          if (it_q == 6'd63) begin
            e_q     <= 6'd63;
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (w_q != '0) begin
            if (w_q[63]) begin
              m_q     <= w_q[63:32];
              f_q     <= '0;
              it_q    <= '0;
              state_q <= ST_LOG;
            end else begin
              w_q <= {w_q[62:0], 1'b0};
              e_q <= e_q - 1'b1;
            end
          end
        end
        ST_LOG: begin
          m_q  <= p[63] ? p[63:32] : p[62:31];
          f_q  <= {f_q[14:0], p[63]};
          it_q <= it_q + 1'b1;
          if (it_q[3:0] == 4'd15) state_q <= ST_FIN;
        end
        ST_FIN: begin
          prod_q <= 48'(t[20:0]) * 48'(DB_K) + 48'(64'h8000_0000);
          if (!lvl_done) state_q <= ST_DB;
        end
        ST_DB: ;
        ST_APPLY: begin
          for (int c = 0; c < 2; c++) begin
            bar_q[c]  <= bar_n[c];
            peak_q[c] <= peak_n[c];
            hold_q[c] <= hold_n[c];
            hcnt_q[c] <= hcnt_n[c];
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_v_q || out_ready_i) begin
            out_v_q  <= 1'b1;
            bar_l_o  <= bar_q[0][OUT_W-1:0];
            bar_r_o  <= bar_q[1][OUT_W-1:0];
            peak_l_o <= peak_q[0][OUT_W-1:0];
            peak_r_o <= peak_q[1][OUT_W-1:0];
            hold_l_o <= hold_q[0][OUT_W-1:0];
            hold_r_o <= hold_q[1][OUT_W-1:0];
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // a finished level: store it and pick the next conversion
      if (lvl_done) begin
        if (!mean_q) begin
          tp_q[ch_q] <= lvl;
          tb_q[ch_q] <= lvl;
        end else begin
          tb_q[ch_q] <= lvl;
        end
        if (!mean_q && cfg_i.meter_mode != MM_PPM) begin
          mean_q  <= 1'b1;
          w_q     <= sum_q[ch_q];
          rem_q   <= '0;
          it_q    <= '0;
          state_q <= ST_DIV;
        end else if (!ch_q) begin
          ch_q    <= 1'b1;
          mean_q  <= 1'b0;
          w_q     <= 64'(pk_q[1]);
          e_q     <= 6'd63;
          state_q <= ST_NORM;
        end else begin
          state_q <= ST_APPLY;
        end
      end
    end
  end

endmodule

/* hw/rtl/stereo_level_meter_ballistics.sv */
// Stereo level meter with PPM, RMS and VU ballistics. Levels come out in
// 1/256 dB, two's complement, from -15360 (-60 dB) to 0. A sample frame is
// taken every clock while the queue has room, by a three-stage front end
// that scales by gain, squares and accumulates per channel; frames that do
// not close a window give no result. Window closes, empty-window ticks and
// stopped ticks pass through a two-entry queue to a sequential back end. A
// window close runs, per channel, a normalize, a 16-bit log2 by repeated
// squaring and a dB conversion for the peak level, and in RMS and VU mode the
// same again after a 64-bit restoring divide for the mean, all on the one
// shared divide, normalize and log unit. The front keeps taking frames while
// the back works until the queue fills. Configuration must be written only
// while the block is idle; the block itself does not enforce this. Writes to
// index 0..3 are meter mode, stereo, gain (Q2.14) and hold ticks.
module stereo_level_meter_ballistics #(
  parameter int MAX_WINDOW  = lmb_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = lmb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_l_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_r_i,
  input  logic                          last_i,
  input  logic                          active_l_i,
  input  logic                          active_r_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lmb_pkg::OUT_W-1:0]     bar_l_o,
  output logic [lmb_pkg::OUT_W-1:0]     bar_r_o,
  output logic [lmb_pkg::OUT_W-1:0]     peak_l_o,
  output logic [lmb_pkg::OUT_W-1:0]     peak_r_o,
  output logic [lmb_pkg::OUT_W-1:0]     hold_l_o,
  output logic [lmb_pkg::OUT_W-1:0]     hold_r_o
);
  import lmb_pkg::*;

  localparam int AW = SAMPLE_BITS + 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int CTL_W = $bits(cmd_ctl_t);
  localparam int QW = CTL_W + 128 + 2 * AW + CW;

  cfg_t          cfg_q;
  logic          q_push, q_push_ready, q_valid, q_pop;
  cmd_ctl_t      f_ctl, b_ctl;
  logic [63:0]   f_sum_l, f_sum_r, b_sum_l, b_sum_r;
  logic [AW-1:0] f_pk_l, f_pk_r, b_pk_l, b_pk_r;
  logic [CW-1:0] f_cnt, b_cnt;
  logic [QW-1:0] q_in, q_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{meter_mode: 2'd1, stereo: 1'b1, gain: 16'd16384, hold_ticks: 8'd30};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_METER_MODE: cfg_q.meter_mode <= cfg_data_i[1:0];
        CFG_STEREO:     cfg_q.stereo     <= cfg_data_i[0];
        CFG_GAIN:       cfg_q.gain       <= cfg_data_i;
        CFG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  lmb_front #(.SB(SAMPLE_BITS), .MW(MAX_WINDOW), .AW(AW), .CW(CW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .mode_i, .sample_l_i, .sample_r_i, .last_i,
    .active_l_i, .active_r_i,
    .gain_i       (cfg_q.gain),
    .push_o       (q_push),
    .push_ready_i (q_push_ready),
    .ctl_o        (f_ctl),
    .sum_l_o      (f_sum_l),
    .sum_r_o      (f_sum_r),
    .pk_l_o       (f_pk_l),
    .pk_r_o       (f_pk_r),
    .cnt_o        (f_cnt)
  );

  assign q_in = {f_ctl, f_sum_l, f_sum_r, f_pk_l, f_pk_r, f_cnt};
  assign {b_ctl, b_sum_l, b_sum_r, b_pk_l, b_pk_r, b_cnt} = q_out;

  lmb_fifo #(.W(QW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i       (q_push),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_out)
  );

  lmb_back #(.SB(SAMPLE_BITS), .AW(AW), .CW(CW)) u_back (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .ctl_i       (b_ctl),
    .sum_l_i     (b_sum_l),
    .sum_r_i     (b_sum_r),
    .pk_l_i      (b_pk_l),
    .pk_r_i      (b_pk_r),
    .cnt_i       (b_cnt),
    .out_valid_o, .out_ready_i,
    .bar_l_o, .bar_r_o, .peak_l_o, .peak_r_o, .hold_l_o, .hold_r_o
  );

  // back end only pops a queued request
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");

  // front end stalls only on a full queue
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> !q_push_ready) else $error("front stalled with queue room");

  // bar and hold levels never rise above 0 dB
  a_levels_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(bar_l_o) <= 0 && $signed(bar_r_o) <= 0 &&
                     $signed(hold_l_o) <= 0 && $signed(hold_r_o) <= 0))
    else $error("level above full scale");

endmodule
